>>> design/lsm_pkg.sv
// Package: types, constants and tables for the log-softmax-at-index unit.
`default_nettype none
package lsm_pkg;
    localparam int unsigned VOCAB_MAX = 262144;
    localparam int unsigned CNT_W     = $clog2(VOCAB_MAX + 1);
    localparam int unsigned SUM_W     = 34;
    localparam logic [23:0] LN2_Q24   = 24'd11629080;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [17:0]        target_index;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [17:0] log_prob;
        logic               target_missing;
    } result_t;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last;
        logic               is_target;
    } entry_t;

    // round(65536 * exp(-2^i/256))
    function automatic logic [15:0] exp_tab(input logic [3:0] i);
        logic [15:0] c;
        case (i)
            4'd0:    c = 16'd65280;
            4'd1:    c = 16'd65026;
            4'd2:    c = 16'd64520;
            4'd3:    c = 16'd63520;
            4'd4:    c = 16'd61565;
            4'd5:    c = 16'd57835;
            4'd6:    c = 16'd51039;
            4'd7:    c = 16'd39750;
            4'd8:    c = 16'd24109;
            4'd9:    c = 16'd8869;
            4'd10:   c = 16'd1200;
            4'd11:   c = 16'd22;
            default: c = 16'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

>>> design/lsm_front.sv
// Front end: takes items, counts elements and marks the target element.
`default_nettype none
module lsm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire lsm_pkg::item_t item,
    input  wire logic          q_full,
    output logic               q_push,
    output lsm_pkg::entry_t    q_entry
);
    import lsm_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             below_max;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;
    assign below_max  = count_reg < CNT_W'(VOCAB_MAX);

    assign q_entry.logit     = item.logit;
    assign q_entry.last      = item.last;
    assign q_entry.is_target = below_max && (count_reg == CNT_W'(item.target_index));

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            if (item.last)
                count_next = '0;
            else if (below_max)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule
`default_nettype wire

>>> design/lsm_fifo.sv
// Two-entry queue between front and back end.
`default_nettype none
module lsm_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lsm_pkg::entry_t push_data,
    input  wire logic            pop,
    output lsm_pkg::entry_t      pop_data,
    output logic                 full,
    output logic                 empty
);
    import lsm_pkg::*;

    entry_t      mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> design/lsm_back.sv
// Back end: running max/sum sequencer, ln evaluation and result register.
`default_nettype none
module lsm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire lsm_pkg::entry_t q_data,
    output logic                 q_pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output lsm_pkg::result_t     result
);
    import lsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXP, S_MLO, S_MHI, S_ADD, S_NORM, S_SQ, S_LNM, S_FIN
    } state_t;

    state_t                state_reg;
    logic signed [15:0]    max_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic signed [15:0]    tlogit_reg;
    logic                  tseen_reg;
    logic                  last_reg;
    logic                  gt_reg;
    logic signed [15:0]    v_reg;
    logic [15:0]           diff_reg;
    logic [16:0]           r_reg;
    logic [3:0]            step_reg;
    logic [50:0]           prod_reg;
    logic [30:0]           m_reg;
    logic [15:0]           frac_reg;
    logic [5:0]            p_reg;
    logic [44:0]           lnp_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic                  gt;
    logic [16:0]           diff;
    logic [32:0]           rmul;
    logic [16:0]           e;
    logic [34:0]           sum_add;
    logic [34:0]           sum_resc;
    logic [SUM_W-1:0]      sum_new;
    logic [SUM_W-1:0]      s_eff;
    logic [5:0]            p;
    logic [63:0]           norm;
    logic [61:0]           sq;
    logic [20:0]           lg;
    logic [12:0]           ln;
    logic signed [17:0]    lp;
    logic                  out_free;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign gt   = q_data.logit > max_reg;
    assign diff = gt ? 17'({q_data.logit[15], q_data.logit} - {max_reg[15], max_reg})
                     : 17'({max_reg[15], max_reg} - {q_data.logit[15], q_data.logit});
    assign rmul = r_reg * exp_tab(step_reg);
    assign e    = (diff_reg[15:12] != 4'd0) ? 17'd0 : r_reg;

    assign sum_add  = {1'b0, sum_reg} + {18'd0, e};
    assign sum_resc = 35'((prod_reg + 51'd32768) >> 16) + 35'd65536;
    always_comb
    begin
        if (gt_reg)
            sum_new = sum_resc[34] ? '1 : sum_resc[SUM_W-1:0];
        else
            sum_new = sum_add[34] ? '1 : sum_add[SUM_W-1:0];
    end

    assign s_eff = (sum_reg < SUM_W'(65536)) ? SUM_W'(65536) : sum_reg;
    always_comb
    begin
        p = 6'd16;
        for (int k = 16; k < SUM_W; k++)
            if (s_eff[k])
                p = 6'(k);
    end
    assign norm = {s_eff, 30'd0} >> p;
    assign sq   = m_reg * m_reg;
    assign lg   = {5'(p_reg - 6'd16), frac_reg};
    assign ln   = 13'((lnp_reg + 45'h80000000) >> 32);
    assign lp   = 18'(tlogit_reg) - 18'(max_reg) - 18'(ln);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_reg       <= 16'sh8000;
            sum_reg       <= '0;
            tlogit_reg    <= '0;
            tseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        v_reg    <= q_data.logit;
                        last_reg <= q_data.last;
                        gt_reg   <= gt;
                        diff_reg <= diff[16] ? 16'hFFFF : diff[15:0];
                        r_reg    <= 17'd65536;
                        step_reg <= 4'd0;
                        if (q_data.is_target)
                        begin
                            tlogit_reg <= q_data.logit;
                            tseen_reg  <= 1'b1;
                        end
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (diff_reg[step_reg])
                        r_reg <= 17'((rmul + 33'd32768) >> 16);
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                        state_reg <= gt_reg ? S_MLO : S_ADD;
                end
                S_MLO:
                begin
                    prod_reg  <= 51'(sum_reg[16:0] * e);
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    prod_reg  <= prod_reg + (51'(sum_reg[33:17] * e) << 17);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    sum_reg <= sum_new;
                    if (gt_reg)
                        max_reg <= v_reg;
                    state_reg <= last_reg ? S_NORM : S_IDLE;
                end
                S_NORM:
                begin
                    p_reg     <= p;
                    m_reg     <= norm[30:0];
                    frac_reg  <= '0;
                    step_reg  <= 4'd0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (sq[61])
                    begin
                        m_reg    <= sq[61:31];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= sq[60:30];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= S_LNM;
                end
                S_LNM:
                begin
                    lnp_reg   <= lg * LN2_Q24;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_reg.target_missing     <= !tseen_reg;
                        out_reg.log_prob           <= tseen_reg ? lp : '0;
                        max_reg                    <= 16'sh8000;
                        sum_reg                    <= '0;
                        tlogit_reg                 <= '0;
                        tseen_reg                  <= 1'b0;
                        state_reg                  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/log_softmax_at_index_unit.sv
// Top level: log-softmax at one index over a stream of Q8.8 logits.
//
//   channel | dir | handshake                  | payload
//   item    | in  | item_valid / item_stall    | lsm_pkg::item_t
//   result  | out | result_valid / result_stall| lsm_pkg::result_t
//
// Each logit passes through the back end in order: pop, 12 serial exp table multiplies,
// then the sum update; when the max rises, a split rescale multiply comes before it.
// A last element then runs normalize, 16 squarings for log2, ln2 scale and the
// result write, which waits while the result register is still stalled.
// Reset clears the running max, sum, count and target capture.
// A two-entry queue lets the front take items while the back end works;
// a stalled result holds in its register while the next vector accumulates.
`default_nettype none
module log_softmax_at_index_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire lsm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output lsm_pkg::result_t      result
);
    import lsm_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_in;
    entry_t q_out;

    lsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    lsm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    lsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );
endmodule
`default_nettype wire

>>> design/lsm_checker.sv
// Port-level checker for the log-softmax-at-index unit, with its bind.
`default_nettype none
module lsm_port_checks (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_stall,
    input  wire lsm_pkg::item_t   item,
    input  wire logic             result_valid,
    input  wire logic             result_stall,
    input  wire lsm_pkg::result_t result
);
    import lsm_pkg::*;

    logic [3:0] pend_reg;
    logic       in_last;
    logic       out_xfer;

    assign in_last  = item_valid && !item_stall && item.last;
    assign out_xfer = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + {3'd0, in_last} - {3'd0, out_xfer};
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 4'd0)
        else $error("result without a closed vector");

    a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.log_prob[17] || result.log_prob == 18'sd0)
        else $error("positive log probability");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.target_missing |-> result.log_prob == 18'sd0)
        else $error("missing target with nonzero result");
endmodule

bind log_softmax_at_index_unit lsm_port_checks u_lsm_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

>>> verif/lsm_checker.sv
// Checker: predicts log-softmax results from observed item transfers and compares them.
`default_nettype none
module lsm_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_stall,
    input  wire lsm_pkg::item_t   item,
    input  wire logic             result_valid,
    input  wire logic             result_stall,
    input  wire lsm_pkg::result_t result,
    output int                    fail_count,
    output int                    pending_results
);
    import lsm_pkg::*;

    localparam logic [63:0] SUM_SAT = 64'h3_FFFF_FFFF;

    logic signed [15:0] cur_max;
    logic [63:0]        cur_sum;
    logic [31:0]        cur_count;
    logic signed [15:0] cur_target;
    logic               cur_seen;
    result_t            expected_results[$];

    function automatic logic [63:0] exp_neg_q16(input logic [31:0] x);
        logic [63:0] r;
        logic [63:0] coef[12];
        coef = '{65280, 65026, 64520, 63520, 61565, 57835,
                 51039, 39750, 24109, 8869, 1200, 22};
        r = 64'd65536;
        if (x >= 32'd4096)
            return 64'd0;
        for (int i = 0; i < 12; i++)
            if (x[i])
                r = (r * coef[i] + 64'd32768) >> 16;
        return r;
    endfunction

    function automatic logic [63:0] ln_q88(input logic [63:0] s_in);
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lg;
        logic [127:0] prod;
        int p;
        s = s_in;
        frac = 0;
        p = 0;
        if (s < 64'd65536)
            s = 64'd65536;
        while (p < 63 && (s >> (p + 1)) != 0)
            p++;
        if (p >= 30)
            m = s >> (p - 30);
        else
            m = s << (30 - p);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        lg = (64'(p - 16) << 16) + frac;
        prod = 128'(lg) * 128'd11629080 + (128'd1 << 31);
        return prod[95:32];
    endfunction

    task automatic clear_vector();
        cur_max = -16'sd32768;
        cur_sum = 0;
        cur_count = 0;
        cur_target = 0;
        cur_seen = 0;
    endtask

    task automatic absorb_logit(input item_t it);
        logic signed [31:0] v;
        logic signed [63:0] lp;
        result_t r;
        v = it.logit;
        if (cur_count == 32'(it.target_index) && cur_count < VOCAB_MAX)
        begin
            cur_target = it.logit;
            cur_seen = 1;
        end
        if (cur_count < VOCAB_MAX)
            cur_count++;
        if (v > cur_max)
        begin
            cur_sum = (cur_sum * exp_neg_q16(32'(v - cur_max)) + 64'd32768) >> 16;
            cur_max = it.logit;
            cur_sum = cur_sum + 64'd65536;
        end
        else
            cur_sum = cur_sum + exp_neg_q16(32'(cur_max - v));
        if (cur_sum > SUM_SAT)
            cur_sum = SUM_SAT;
        if (it.last)
        begin
            if (cur_seen)
            begin
                lp = 64'(cur_target) - 64'(cur_max) - $signed(ln_q88(cur_sum));
                r.log_prob = lp[17:0];
                r.target_missing = 0;
            end
            else
            begin
                r.log_prob = 0;
                r.target_missing = 1;
            end
            expected_results.push_back(r);
            clear_vector();
        end
    endtask

    initial
    begin
        fail_count = 0;
        clear_vector();
    end

    assign pending_results = expected_results.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer: log_prob=%0d", result.log_prob);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (result.log_prob !== e.log_prob)
                    begin
                        $error("log_prob: expected %0d, got %0d", e.log_prob, result.log_prob);
                        fail_count++;
                    end
                    if (result.target_missing !== e.target_missing)
                    begin
                        $error("target_missing: expected %0d, got %0d",
                               e.target_missing, result.target_missing);
                        fail_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                absorb_logit(item);
        end
    end
endmodule
`default_nettype wire

>>> verif/tb_log_softmax_at_index_unit.sv
// Testbench top: drives logit vectors and random stalls, and reports the verdict.
`default_nettype none
module tb_log_softmax_at_index_unit;
    import lsm_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1800;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      fail_count;
    int      pending_results;
    int      idle_cycles;

    log_softmax_at_index_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    lsm_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial
    begin
        clk = 0;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_stall = 0;
    end

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_logit(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'sh8000;
            2: return 16'sh7FFF;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // one transfer after a random gap; valid drops only during that gap
    task automatic send_logit(input logic signed [15:0] v, input logic [17:0] tidx,
                              input logic lst);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            item_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1;
        item.logit <= v;
        item.target_index <= tidx;
        item.last <= lst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_vector(input int len, input logic [17:0] tidx, input int mode);
        for (int i = 0; i < len; i++)
            send_logit(pick_logit(mode), tidx, i == len - 1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 9) < 3)
                result_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : !result_stall;
            else
                result_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_log_softmax_at_index_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int len;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: single element, target hit and miss, extremes, max rises
        send_logit(16'sh8000, 18'd0, 1);
        send_logit(16'sh7FFF, 18'd1, 1);
        send_logit(16'sh7FFF, 18'h3FFFF, 1);
        send_logit(16'sh8000, 18'd0, 0);
        send_logit(16'sh7FFF, 18'd0, 1);
        send_logit(16'sh7FFF, 18'd1, 0);
        send_logit(16'sh8000, 18'd1, 1);
        send_logit(16'sh0000, 18'd2, 0);
        send_logit(16'sh0100, 18'd2, 0);
        send_logit(16'sh0200, 18'd2, 1);
        send_vector(6, 18'd5, 3);
        send_vector(4, 18'd4, 3);
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0: send_vector(len, 18'($urandom), 0);
                1: send_vector(len, 18'($urandom_range(0, len + 1)), 0);
                2: send_vector(len, 18'($urandom_range(0, len - 1)), $urandom_range(1, 2));
                default: send_vector(len, 18'($urandom_range(0, len)), 3);
            endcase
            sent += len;
        end
        item_valid <= 0;
        while (pending_results != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb_log_softmax_at_index_unit: PASS");
        else
            $display("tb_log_softmax_at_index_unit: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
design/lsm_pkg.sv
design/lsm_front.sv
design/lsm_fifo.sv
design/lsm_back.sv
design/log_softmax_at_index_unit.sv
design/lsm_checker.sv
verif/lsm_checker.sv
verif/tb_log_softmax_at_index_unit.sv
